/* design/pis_pkg.sv */
// ----------------------------------------------------------------------------
// pis_pkg: shared types and constants for the point-in-shape hit test
// Request op codes, shape kinds, field widths, sequencer state and the
// control records passed between the sequencer, the test unit and the top.
// ----------------------------------------------------------------------------
package pis_pkg;

	localparam int OP_W      = 2;
	localparam int KIND_W    = 2;
	localparam int SIZE_W    = 15;
	localparam int SIZE_SQ_W = 2 * SIZE_W;
	localparam int HIT_IDX_W = 4;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic [KIND_W-1:0] KIND_BOX = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CYL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SPH = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DONE
	} seq_state_t;

	// One slot handed to the test unit
	typedef struct packed {
		logic valid;
		logic last;
	} scan_tag_t;

	// One slot verdict coming back from the test unit
	typedef struct packed {
		logic valid;
		logic last;
		logic match;
	} test_res_t;

	typedef struct packed {
		logic      idle;
		logic      load;
		scan_tag_t issue;
	} seq_ctrl_t;

endpackage

/* design/pis_ram.sv */
// ----------------------------------------------------------------------------
// pis_ram: shape table storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pis_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 95,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/pis_hit_test.sv */
// ----------------------------------------------------------------------------
// pis_hit_test: pipelined containment test, one slot per cycle
// Stages: table read, deltas, squares and box compares, partial sum,
// final sum and kind select.
// ----------------------------------------------------------------------------
module pis_hit_test
	import pis_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int IDX_W      = 4,
	parameter int WORD_W     = KIND_W + 3 * COORD_BITS + 3 * SIZE_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scan_tag_t                    issue,
	input  logic [IDX_W-1:0]             issue_idx,
	input  logic                         issue_slot_vld,
	input  logic [WORD_W-1:0]            slot_word,
	input  logic signed [COORD_BITS-1:0] pt_x,
	input  logic signed [COORD_BITS-1:0] pt_y,
	input  logic signed [COORD_BITS-1:0] pt_z,
	output test_res_t                    res,
	output logic [IDX_W-1:0]             res_idx
);

	localparam int CB    = COORD_BITS;
	localparam int D_W   = CB + 1;
	localparam int SQ_W  = 2 * CB;
	localparam int BOX_W = (CB + 1 > SIZE_W) ? CB + 1 : SIZE_W;
	localparam int CMP_W = (SQ_W + 4 > SIZE_SQ_W) ? SQ_W + 4 : SIZE_SQ_W;
	localparam int SA_LO = 0;
	localparam int SB_LO = SIZE_W;
	localparam int SC_LO = 2 * SIZE_W;
	localparam int CX_LO = 3 * SIZE_W;
	localparam int CY_LO = CX_LO + CB;
	localparam int CZ_LO = CY_LO + CB;
	localparam int KD_LO = CZ_LO + CB;

	// stage 1: table word arrives
	scan_tag_t        tag_s1, tag_s2, tag_s3, tag_s4;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic             vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [CB-1:0] cx, cy, cz;
	logic signed [D_W-1:0] dfx, dfy, dfz, ngx, ngy, ngz;
	logic [SIZE_W-1:0]     sa, sb, sc;

	assign cx = $signed(slot_word[CX_LO +: CB]);
	assign cy = $signed(slot_word[CY_LO +: CB]);
	assign cz = $signed(slot_word[CZ_LO +: CB]);
	assign sa = slot_word[SA_LO +: SIZE_W];
	assign sb = slot_word[SB_LO +: SIZE_W];
	assign sc = slot_word[SC_LO +: SIZE_W];

	assign dfx = D_W'(pt_x) - D_W'(cx);
	assign dfy = D_W'(pt_y) - D_W'(cy);
	assign dfz = D_W'(pt_z) - D_W'(cz);
	assign ngx = -dfx;
	assign ngy = -dfy;
	assign ngz = -dfz;

	// stage 2: magnitudes of the deltas
	logic [CB-1:0]     ax_s2, ay_s2, az_s2;
	logic [SIZE_W-1:0] sa_s2, sb_s2, sc_s2;
	logic [KIND_W-1:0] kind_s2, kind_s3, kind_s4;

	// stage 3: squares and per-axis compares
	logic [SQ_W-1:0]      sqx_s3, sqy_s3, sqz_s3;
	logic [SIZE_SQ_W-1:0] sb2_s3, sb2_s4;
	logic                 box_s3, zok_s3, box_s4, zok_s4;
	logic                 bx_ok, by_ok, bz_ok;

	// stage 4: partial sum
	logic [SQ_W:0]   sxy_s4;
	logic [SQ_W-1:0] sqz_s4;

	// stage 5: final verdict
	logic [SQ_W+1:0] sxyz;
	logic            cyl_ok, sph_ok, match;
	test_res_t       res_s5;
	logic [IDX_W-1:0] idx_s5;

	assign bx_ok = BOX_W'({ax_s2, 1'b0}) < BOX_W'(sa_s2);
	assign by_ok = BOX_W'({ay_s2, 1'b0}) < BOX_W'(sb_s2);
	assign bz_ok = BOX_W'({az_s2, 1'b0}) < BOX_W'(sc_s2);

	assign sxyz   = (SQ_W + 2)'(sxy_s4) + (SQ_W + 2)'(sqz_s4);
	assign cyl_ok = (CMP_W'({sxy_s4, 2'b00}) < CMP_W'(sb2_s4)) && zok_s4;
	assign sph_ok = CMP_W'({sxyz, 2'b00}) < CMP_W'(sb2_s4);

	always_comb begin
		unique case (kind_s4)
			KIND_BOX: match = box_s4;
			KIND_CYL: match = cyl_ok;
			KIND_SPH: match = sph_ok;
			default:  match = 1'b0;
		endcase
	end

	// Tags advance every cycle; an empty slot flows as a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			res_s5 <= '0;
		end else begin
			tag_s1       <= issue;
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			tag_s4       <= tag_s3;
			res_s5.valid <= tag_s4.valid;
			res_s5.last  <= tag_s4.last;
			res_s5.match <= tag_s4.valid && vld_s4 && match;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_idx;
		vld_s1 <= issue_slot_vld;

		idx_s2  <= idx_s1;
		vld_s2  <= vld_s1;
		ax_s2   <= dfx[D_W-1] ? ngx[CB-1:0] : dfx[CB-1:0];
		ay_s2   <= dfy[D_W-1] ? ngy[CB-1:0] : dfy[CB-1:0];
		az_s2   <= dfz[D_W-1] ? ngz[CB-1:0] : dfz[CB-1:0];
		sa_s2   <= sa;
		sb_s2   <= sb;
		sc_s2   <= sc;
		kind_s2 <= slot_word[KD_LO +: KIND_W];

		idx_s3  <= idx_s2;
		vld_s3  <= vld_s2;
		sqx_s3  <= ax_s2 * ax_s2;
		sqy_s3  <= ay_s2 * ay_s2;
		sqz_s3  <= az_s2 * az_s2;
		sb2_s3  <= sb_s2 * sb_s2;
		box_s3  <= bx_ok && by_ok && bz_ok;
		zok_s3  <= bz_ok;
		kind_s3 <= kind_s2;

		idx_s4  <= idx_s3;
		vld_s4  <= vld_s3;
		sxy_s4  <= (SQ_W + 1)'(sqx_s3) + (SQ_W + 1)'(sqy_s3);
		sqz_s4  <= sqz_s3;
		sb2_s4  <= sb2_s3;
		box_s4  <= box_s3;
		zok_s4  <= zok_s3;
		kind_s4 <= kind_s3;

		idx_s5 <= idx_s4;
	end

	assign res     = res_s5;
	assign res_idx = idx_s5;

endmodule

/* design/pis_seq.sv */
// ----------------------------------------------------------------------------
// pis_seq: query sequencer
// Walks the slot counter through the table, waits for the last verdict and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pis_seq
	import pis_pkg::*;
#(
	parameter int MAX_SHAPES = 16,
	parameter int IDX_W      = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  test_res_t        res,
	input  logic             out_free,
	output seq_ctrl_t        ctrl,
	output logic [IDX_W-1:0] scan_idx
);

	seq_state_t       state_q, state_nxt;
	logic [IDX_W-1:0] cnt_q;
	logic             last_slot;

	assign last_slot = (cnt_q == IDX_W'(MAX_SHAPES - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_nxt = ST_SCAN;
			ST_SCAN: if (last_slot) state_nxt = ST_WAIT;
			ST_WAIT: if (res.valid && res.last) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: ctrl.idle = 1'b1;
			ST_SCAN: begin
				ctrl.issue.valid = 1'b1;
				ctrl.issue.last  = last_slot;
			end
			ST_WAIT: ctrl = '0;
			ST_DONE: ctrl.load = out_free;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	assign scan_idx = cnt_q;

endmodule

/* design/point_in_shape_hit_test_unit.sv */
// ----------------------------------------------------------------------------
// point_in_shape_hit_test_unit: shape table with point containment query
// Queries: a query's result goes to the output register once the slot scan
//   through the shared test pipeline, one slot per cycle, has given its last
//   verdict and the output register is free.
// Requests: writes and clears are taken while the sequencer is idle. A query holds the
//   input off until its result is in the output register, so queries go one
//   at a time, each scan finishing before the next query is taken.
// Reset: all slots invalid, no result pending; table contents are unknown.
// ----------------------------------------------------------------------------
module point_in_shape_hit_test_unit
	import pis_pkg::*;
#(
	parameter int MAX_SHAPES = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [OP_W-1:0]              op,
	input  logic [HIT_IDX_W-1:0]         entry_index,
	input  logic [KIND_W-1:0]            shape_kind,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic [SIZE_W-1:0]            size_a,
	input  logic [SIZE_W-1:0]            size_b,
	input  logic [SIZE_W-1:0]            size_c,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [HIT_IDX_W-1:0]         hit_index
);

	localparam int IDX_W  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
	localparam int WORD_W = KIND_W + 3 * COORD_BITS + 3 * SIZE_W;

	// Request decode: everything lands only while the sequencer is idle.
	seq_ctrl_t        ctrl;
	test_res_t        res;
	logic [IDX_W-1:0] res_idx;
	logic [IDX_W-1:0] scan_idx;
	logic             accept, start, do_write, do_clear, out_free;
	logic [IDX_W+HIT_IDX_W-1:0] wr_addr_ext;
	logic [IDX_W-1:0]           wr_addr;
	logic [WORD_W-1:0]          wr_word, rd_word;

	assign in_stall = !ctrl.idle;
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (op == OP_QUERY);
	assign do_clear = accept && (op == OP_CLEAR);
	// drop writes aimed past the end of the table
	assign do_write = accept && (op == OP_WRITE) && (32'(entry_index) < 32'(MAX_SHAPES));

	assign wr_addr_ext = {IDX_W'(0), entry_index};
	assign wr_addr     = wr_addr_ext[IDX_W-1:0];
	assign wr_word     = {shape_kind, pos_z, pos_y, pos_x, size_c, size_b, size_a};

	// Valid bits: set on write, all dropped at once by a clear.
	logic [MAX_SHAPES-1:0] slot_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (do_clear) begin
			slot_valid_q <= '0;
		end else if (do_write) begin
			slot_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Hold the query point for the whole scan.
	logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q, pt_z_q;

	always_ff @(posedge clk) begin
		if (start) begin
			pt_x_q <= pos_x;
			pt_y_q <= pos_y;
			pt_z_q <= pos_z;
		end
	end

	pis_ram #(
		.DEPTH (MAX_SHAPES),
		.WIDTH (WORD_W),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (do_write),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_en   (ctrl.issue.valid),
		.rd_addr (scan_idx),
		.rd_data (rd_word)
	);

	pis_seq #(
		.MAX_SHAPES (MAX_SHAPES),
		.IDX_W      (IDX_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.res      (res),
		.out_free (out_free),
		.ctrl     (ctrl),
		.scan_idx (scan_idx)
	);

	// The valid bit is sampled at issue and travels with the slot.
	pis_hit_test #(
		.COORD_BITS (COORD_BITS),
		.IDX_W      (IDX_W),
		.WORD_W     (WORD_W)
	) u_test (
		.clk            (clk),
		.arst_n         (arst_n),
		.issue          (ctrl.issue),
		.issue_idx      (scan_idx),
		.issue_slot_vld (slot_valid_q[scan_idx]),
		.slot_word      (rd_word),
		.pt_x           (pt_x_q),
		.pt_y           (pt_y_q),
		.pt_z           (pt_z_q),
		.res            (res),
		.res_idx        (res_idx)
	);

	// Keep the first match; verdicts come back in slot order.
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (res.valid && res.match) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res.match && !found_q) begin
			found_idx_q <= res_idx;
		end
	end

	// Output register: frees the request side while a result waits.
	logic                        out_valid_q, hit_q;
	logic [HIT_IDX_W-1:0]        hit_index_q;
	logic [IDX_W+HIT_IDX_W-1:0]  found_idx_ext;

	assign out_free      = !out_valid_q || !out_stall;
	assign found_idx_ext = {HIT_IDX_W'(0), found_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			hit_q       <= found_q;
			hit_index_q <= found_q ? found_idx_ext[HIT_IDX_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_index = hit_index_q;

	// A result never lands on top of one still waiting.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending result");

	// The test pipeline is empty whenever requests are being taken.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !ctrl.idle)
		else $error("slot verdict while idle");

	// The first match of a scan is never replaced.
	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !start) |=> (found_q && $stable(found_idx_q)))
		else $error("first match lost");

	// A miss reports slot zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !hit_q) |-> (hit_index_q == '0))
		else $error("miss with nonzero index");

endmodule

/* tb/tb_point_in_shape_hit_test_unit.sv */
// ----------------------------------------------------------------------------
// tb_point_in_shape_hit_test_unit: self-checking bench for the shape hit test
// Drives write, clear and query requests into the unit and keeps a private
// copy of the shape table. Each query is resolved against that copy, and
// every returned hit or miss is compared in order. Traffic runs under four
// idle and stall mixes on the request and result channels.
// ----------------------------------------------------------------------------
module tb_point_in_shape_hit_test_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pis_pkg::*;

	localparam int SLOTS        = 16;
	localparam int CLK_PERIOD   = 12;
	localparam int QUERY_CYCLES = SLOTS + 7;
	// generous: every request a query, long gaps on both sides, several times over
	localparam int TIMEOUT_NS   = 20_000_000;

	// op code 3 and kind 3 have no name in the package
	localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	localparam logic signed [15:0] CMIN = 16'sh8000;
	localparam logic signed [15:0] CMAX = 16'sh7FFF;
	localparam logic [SIZE_W-1:0]  SMAX = 15'h7FFF;

	// ------------------------------------------------------------------------
	// Shape table mirror and ordered list of expected query answers
	// ------------------------------------------------------------------------
	class shape_hit_board;
		typedef struct packed {
			logic                 hit;
			logic [HIT_IDX_W-1:0] slot;
		} lookup_t;

		bit          live[SLOTS];
		logic [1:0]  kind[SLOTS];
		longint      center[SLOTS][3];
		longint      extent[SLOTS][3];
		lookup_t     expected_hits[$];
		int          mismatches;
		int          queries_checked;
		int          hits_seen;

		function new();
			foreach (live[i])
				live[i] = 1'b0;
		endfunction

		function longint mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// strict containment; sizes are halved by doubling the distances
		function bit encloses(int s, longint px, longint py, longint pz);
			longint dx, dy, dz, sa, sb, sc;
			dx = px - center[s][0];
			dy = py - center[s][1];
			dz = pz - center[s][2];
			sa = extent[s][0];
			sb = extent[s][1];
			sc = extent[s][2];
			case (kind[s])
				KIND_BOX: return 2 * mag(dx) < sa && 2 * mag(dy) < sb && 2 * mag(dz) < sc;
				KIND_CYL: return 4 * (dx * dx + dy * dy) < sb * sb && 2 * mag(dz) < sc;
				KIND_SPH: return 4 * (dx * dx + dy * dy + dz * dz) < sb * sb;
				default:  return 1'b0;
			endcase
		endfunction

		function lookup_t first_hit(longint px, longint py, longint pz);
			lookup_t res;
			res = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (live[i] && encloses(i, px, py, pz)) begin
					res.hit  = 1'b1;
					res.slot = i[HIT_IDX_W-1:0];
					return res;
				end
			end
			return res;
		endfunction

		function void note_request(input logic [OP_W-1:0] code,
			input logic [HIT_IDX_W-1:0] idx, input logic [KIND_W-1:0] k,
			input logic signed [15:0] x, y, z, input logic [SIZE_W-1:0] a, b, c);
			case (code)
				OP_WRITE: begin
					live[idx]      = 1'b1;
					kind[idx]      = k;
					center[idx][0] = x;
					center[idx][1] = y;
					center[idx][2] = z;
					extent[idx][0] = a;
					extent[idx][1] = b;
					extent[idx][2] = c;
				end
				OP_CLEAR: begin
					foreach (live[i])
						live[i] = 1'b0;
				end
				OP_QUERY: expected_hits.push_back(first_hit(x, y, z));
				default: ;
			endcase
		endfunction

		task report_mismatch(input string msg);
			if (mismatches < 50)
				$display("[%0t] MISMATCH: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(input logic got_hit, input logic [HIT_IDX_W-1:0] got_slot);
			lookup_t want;
			if (expected_hits.size() == 0) begin
				report_mismatch($sformatf("result hit=%b index=%0d with no query pending",
					got_hit, got_slot));
				return;
			end
			want = expected_hits.pop_front();
			queries_checked++;
			if (want.hit)
				hits_seen++;
			if (got_hit !== want.hit)
				report_mismatch($sformatf("query %0d: hit=%b, expected %b",
					queries_checked, got_hit, want.hit));
			if (got_slot !== want.slot)
				report_mismatch($sformatf("query %0d: hit_index=%0d, expected %0d",
					queries_checked, got_slot, want.slot));
		endtask

		task close_out();
			if (expected_hits.size() != 0)
				report_mismatch($sformatf("%0d query results never arrived",
					expected_hits.size()));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic [OP_W-1:0]           op          = OP_NONE;
	logic [HIT_IDX_W-1:0]      entry_index = '0;
	logic [KIND_W-1:0]         shape_kind  = KIND_BOX;
	logic signed [15:0]        pos_x       = '0;
	logic signed [15:0]        pos_y       = '0;
	logic signed [15:0]        pos_z       = '0;
	logic [SIZE_W-1:0]         size_a      = '0;
	logic [SIZE_W-1:0]         size_b      = '0;
	logic [SIZE_W-1:0]         size_c      = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic                      hit;
	logic [HIT_IDX_W-1:0]      hit_index;

	shape_hit_board board = new();

	// idle and stall odds in percent, set per traffic phase
	int idle_pct  = 0;
	int stall_pct = 0;
	// accepted requests that the block acts on (op code 3 is not counted)
	int sent      = 0;

	// what the stimulus side believes is in the table, used to aim queries
	bit                   gen_live[SLOTS];
	logic [KIND_W-1:0]    gen_kind[SLOTS];
	logic signed [15:0]   gen_center[SLOTS][3];
	logic [SIZE_W-1:0]    gen_size[SLOTS][3];

	always #(CLK_PERIOD / 2) clk = ~clk;

	point_in_shape_hit_test_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.entry_index(entry_index),
		.shape_kind (shape_kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.size_a     (size_a),
		.size_b     (size_b),
		.size_c     (size_c),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.hit_index  (hit_index)
	);

	// Result side back-pressure: redraw the stall every cycle at the phase odds.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watch both channels. Record a request before checking a result on the
	// same edge, so a query accepted while an older result leaves still lines
	// up behind it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_request(op, entry_index, shape_kind, pos_x, pos_y, pos_z,
					size_a, size_b, size_c);
			if (out_valid && !out_stall)
				board.check_result(hit, hit_index);
		end
	end

	// Present one request, idling first at the phase odds, and hold it until
	// the block takes it. Returns on the accepting edge.
	task automatic send_request(input logic [OP_W-1:0] code,
		input logic [HIT_IDX_W-1:0] idx, input logic [KIND_W-1:0] k,
		input logic signed [15:0] x, y, z, input logic [SIZE_W-1:0] a, b, c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op          <= code;
		entry_index <= idx;
		shape_kind  <= k;
		pos_x       <= x;
		pos_y       <= y;
		pos_z       <= z;
		size_a      <= a;
		size_b      <= b;
		size_c      <= c;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		// track the table so later queries can be aimed at live shapes
		if (code == OP_WRITE) begin
			gen_live[idx]      = 1'b1;
			gen_kind[idx]      = k;
			gen_center[idx][0] = x;
			gen_center[idx][1] = y;
			gen_center[idx][2] = z;
			gen_size[idx][0]   = a;
			gen_size[idx][1]   = b;
			gen_size[idx][2]   = c;
		end else if (code == OP_CLEAR) begin
			foreach (gen_live[i])
				gen_live[i] = 1'b0;
		end
		if (code != OP_NONE)
			sent++;
	endtask

	// Query a point; the unused fields carry random bits.
	task automatic query_at(input logic signed [15:0] x, y, z);
		send_request(OP_QUERY, HIT_IDX_W'($urandom), KIND_W'($urandom), x, y, z,
			SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
	endtask

	// Random traffic: mostly queries aimed at or just past the surfaces of live
	// shapes, plus writes of mostly modest shapes, with clears and raw noise mixed in.
	task automatic run_traffic(input int n);
		int                 target;
		int                 r;
		int                 s;
		int                 t;
		int                 h;
		int                 off;
		logic [SIZE_W-1:0]  ext;
		logic [KIND_W-1:0]  k;
		logic signed [15:0] pt[3];
		logic [SIZE_W-1:0]  sz[3];
		target = sent + n;
		while (sent < target) begin
			r = $urandom_range(99);
			// find some live slot, if any, to aim at or to overlap
			s = $urandom_range(SLOTS - 1);
			for (t = 0; t < SLOTS && !gen_live[s]; t++)
				s = (s + 1) % SLOTS;
			if (r < 3) begin
				send_request(OP_CLEAR, HIT_IDX_W'($urandom), KIND_W'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom),
					SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
			end else if (r < 8) begin
				// noise: any op code, any field bits
				send_request(OP_W'($urandom), HIT_IDX_W'($urandom), KIND_W'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom),
					SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
			end else if (r < 26) begin
				k = ($urandom_range(9) == 0) ? KIND_NONE : KIND_W'($urandom_range(2));
				for (int i = 0; i < 3; i++) begin
					sz[i] = ($urandom_range(6) == 0) ? SIZE_W'($urandom)
						: SIZE_W'($urandom_range(4000));
					// overlap an existing shape now and then to exercise priority
					if (gen_live[s] && $urandom_range(2) == 0)
						pt[i] = 16'(int'(gen_center[s][i]) + $urandom_range(1000) - 500);
					else
						pt[i] = 16'($urandom);
				end
				send_request(OP_WRITE, HIT_IDX_W'($urandom), k, pt[0], pt[1], pt[2],
					sz[0], sz[1], sz[2]);
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (gen_live[s] && $urandom_range(3) != 0) begin
						// spread around the center out to just past the surface
						case (gen_kind[s])
							KIND_CYL: ext = (i < 2) ? gen_size[s][1] : gen_size[s][2];
							KIND_SPH: ext = gen_size[s][1];
							default:  ext = gen_size[s][i];
						endcase
						h = int'(ext) / 2 + 2;
						off = int'($urandom_range(2 * h)) - h;
						pt[i] = 16'(int'(gen_center[s][i]) + off);
					end else begin
						pt[i] = 16'($urandom);
					end
				end
				query_at(pt[0], pt[1], pt[2]);
			end
		end
	endtask

	initial begin
		foreach (gen_live[i])
			gen_live[i] = 1'b0;

		// hold reset at the start, then release it once
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling: empty table, boundaries, priority,
		// ignored op code, never-matching kind, zero sizes, clear.
		query_at(16'sd0, 16'sd0, 16'sd0);
		send_request(OP_NONE, 4'hF, KIND_NONE, CMAX, CMAX, CMAX, SMAX, SMAX, SMAX);
		send_request(OP_WRITE, 4'd0, KIND_BOX, 16'sd0, 16'sd0, 16'sd0, 15'd4, 15'd4, 15'd4);
		query_at(16'sd1, -16'sd1, 16'sd1);
		query_at(16'sd2, 16'sd0, 16'sd0);
		send_request(OP_WRITE, 4'd15, KIND_SPH, CMIN, CMIN, CMIN, 15'd0, SMAX, 15'd0);
		query_at(CMIN, CMIN, CMIN);
		send_request(OP_WRITE, 4'd3, KIND_CYL, CMAX, CMAX, CMAX, 15'd0, SMAX, SMAX);
		query_at(CMAX, CMAX, CMAX);
		query_at(16'sd24767, CMAX, CMAX);
		query_at(CMAX, CMIN, 16'sd0);
		send_request(OP_WRITE, 4'd1, KIND_NONE, 16'sd0, 16'sd0, 16'sd0, SMAX, SMAX, SMAX);
		send_request(OP_WRITE, 4'd2, KIND_BOX, 16'sd0, 16'sd0, 16'sd0, 15'd0, SMAX, SMAX);
		query_at(16'sd0, 16'sd0, 16'sd0);
		send_request(OP_WRITE, 4'd0, KIND_BOX, 16'sd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 15'd0);
		query_at(16'sd0, 16'sd0, 16'sd0);
		send_request(OP_CLEAR, 4'd0, KIND_BOX, 16'sd0, 16'sd0, 16'sd0, 15'd0, 15'd0, 15'd0);
		query_at(CMIN, CMIN, CMIN);
		send_request(OP_WRITE, 4'd5, KIND_SPH, 16'sd0, 16'sd0, 16'sd0, 15'd0, 15'd10, 15'd0);
		query_at(16'sd2, 16'sd2, 16'sd2);
		query_at(16'sd3, 16'sd3, 16'sd3);
		query_at(CMIN, CMAX, CMIN);

		// Random part under four mixes of request idling and result stalls.
		idle_pct = 0;  stall_pct = 0;  run_traffic(400);
		idle_pct = 80; stall_pct = 0;  run_traffic(400);
		idle_pct = 0;  stall_pct = 80; run_traffic(400);
		idle_pct = 35; stall_pct = 35; run_traffic(400);
		in_valid <= 1'b0;

		// drain outstanding queries, then give the pipeline time to misbehave
		while (board.expected_hits.size() != 0)
			@(posedge clk);
		repeat (2 * QUERY_CYCLES + 10) @(posedge clk);
		board.close_out();

		$display("Covered %0d requests: %0d query results checked, %0d of them hits,",
			sent, board.queries_checked, board.hits_seen);
		$display("under no idling, heavy request gaps, heavy result stalls and both mixed.");
		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d query results outstanding",
			board.expected_hits.size());
		$display("FAIL");
		$finish;
	end

endmodule
